### rtl/core/gcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_pkg: shared constants, types and helpers of the gradient colour map
// Table size, fixed-point widths, divide-by-span reciprocal and palette pick.
// ----------------------------------------------------------------------------
package gcm_pkg;

    // Table points and palette size
    localparam int unsigned LUT_ENTRIES = 256;
    localparam int unsigned MAX_COLORS  = 8;

    // Widths fixed by the interface
    localparam int unsigned POS_W      = 18;
    localparam int unsigned CNT_W      = 4;
    localparam int unsigned SEL_W      = 3;
    localparam int unsigned REG_W      = 48;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned COLOR_W    = 3 * CHAN_W;
    localparam int unsigned T_W        = 17;

    // Derived from the table size
    localparam int unsigned IDX_W      = $clog2(LUT_ENTRIES);
    localparam int unsigned SPAN_INT   = LUT_ENTRIES - 1;
    localparam int unsigned P_W        = IDX_W + SEL_W;
    localparam int unsigned NUM_W      = IDX_W + CHAN_W;
    localparam int unsigned RECIP_W    = NUM_W + 1;

    localparam logic [IDX_W-1:0]   SPAN      = IDX_W'(SPAN_INT);
    localparam logic [IDX_W-1:0]   HALF_SPAN = IDX_W'(SPAN_INT / 2);
    // floor(2^NUM_W / span): the quotient estimate is at most one low
    localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'((64'd1 << NUM_W) / SPAN_INT);
    localparam logic [T_W-1:0]     ONE_Q16   = T_W'(65536);

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLOR_COUNT = 3'd0,
        REG_COLORS_0_1  = 3'd1,
        REG_COLORS_2_3  = 3'd2,
        REG_COLORS_4_5  = 3'd3,
        REG_COLORS_6_7  = 3'd4
    } cfg_reg_t;

    typedef logic [IDX_W-1:0]   rem_t;
    typedef logic [CHAN_W-1:0]  chan_t;
    typedef logic [COLOR_W-1:0] color_t;

    // red occupies the lowest byte
    typedef struct packed {
        chan_t blue;
        chan_t green;
        chan_t red;
    } pixel_t;

    // Pick control colour k out of the four packed palette words
    function automatic color_t pick_color(input logic [4*REG_W-1:0] palette,
                                          input logic [SEL_W-1:0]   k);
        color_t c;
        unique case (k)
            3'd0:    c = palette[0*COLOR_W +: COLOR_W];
            3'd1:    c = palette[1*COLOR_W +: COLOR_W];
            3'd2:    c = palette[2*COLOR_W +: COLOR_W];
            3'd3:    c = palette[3*COLOR_W +: COLOR_W];
            3'd4:    c = palette[4*COLOR_W +: COLOR_W];
            3'd5:    c = palette[5*COLOR_W +: COLOR_W];
            3'd6:    c = palette[6*COLOR_W +: COLOR_W];
            default: c = palette[7*COLOR_W +: COLOR_W];
        endcase
        return c;
    endfunction

endpackage

### rtl/core/gcm_chan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_chan: one colour channel blend
// Weighted sum of the two control values, then a rounded divide by the span
// done as reciprocal multiply and a single correction step (three stages).
// ----------------------------------------------------------------------------
module gcm_chan import gcm_pkg::*; (
    input  logic  aclk,
    input  logic  en,
    input  chan_t a,
    input  chan_t b,
    input  rem_t  rem,
    output chan_t q
);

    logic [NUM_W-1:0]         prod_a;
    logic [NUM_W-1:0]         prod_b;
    logic [NUM_W-1:0]         num_next;
    logic [NUM_W-1:0]         num_reg;
    logic [NUM_W+RECIP_W-1:0] qprod;
    chan_t                    qest_next;
    chan_t                    qest_reg;
    logic [NUM_W-1:0]         num2_reg;
    logic [NUM_W-1:0]         back;
    logic [NUM_W-1:0]         resid;
    chan_t                    q_next;
    chan_t                    q_reg;

    // a*(span-rem) + b*rem + span/2
    assign prod_a   = {{IDX_W{1'b0}}, a} * {{CHAN_W{1'b0}}, rem_t'(SPAN - rem)};
    assign prod_b   = {{IDX_W{1'b0}}, b} * {{CHAN_W{1'b0}}, rem};
    assign num_next = prod_a + prod_b + {{CHAN_W{1'b0}}, HALF_SPAN};

    // estimate: floor(num * recip / 2^NUM_W), never above the true quotient
    assign qprod     = {{RECIP_W{1'b0}}, num_reg} * {{NUM_W{1'b0}}, RECIP};
    assign qest_next = qprod[NUM_W +: CHAN_W];

    // bump by one where the residue still covers a whole span
    assign back   = {{IDX_W{1'b0}}, qest_reg} * {{CHAN_W{1'b0}}, SPAN};
    assign resid  = num2_reg - back;
    assign q_next = (resid >= {{CHAN_W{1'b0}}, SPAN}) ? chan_t'(qest_reg + 1'b1) : qest_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg  <= num_next;
            qest_reg <= qest_next;
            num2_reg <= num_reg;
            q_reg    <= q_next;
        end
    end

    assign q = q_reg;

endmodule

### rtl/core/gcm_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_skid: output register with skid stage
// Registers the result channel and keeps upstream ready a plain flop.
// ----------------------------------------------------------------------------
module gcm_skid import gcm_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  pixel_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output pixel_t out_data
);

    logic   out_valid_reg;
    pixel_t out_data_reg;
    logic   skid_valid_reg;
    pixel_t skid_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !out_valid_reg) begin
            // output slot free: drain the skid first
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= in_valid;
            end
        end else if (in_valid && !skid_valid_reg) begin
            // output stalled: park the incoming transfer
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready || !out_valid_reg) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        if (!skid_valid_reg) begin
            skid_data_reg <= in_data;
        end
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds data while output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready && in_valid))
        else $error("skid stage filled without an output stall");

    a_out_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("stalled result changed or dropped");

endmodule

### rtl/core/gradient_color_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_color_map: pseudo-colour mapper for a scalar stream
// Maps a Q1.16 position onto a ramp of up to eight software-loaded colours.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one position per transfer, signed Q1.16 in s_tdata[17:0]
//   (65536 is 1.0). Negative values act as 0, values above 1.0 act as 1.0.
//   Result channel m_*: one RGB colour per input transfer, in order.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index at the
//   clock edge (0 colour count, 1..4 colour pairs); other indexes are dropped.
//   Write configuration only while no transfer is in flight.
// Timing:
//   Seven pipeline stages and the output register; one transfer per cycle is
//   sustained while the receiver keeps up. Every stage is a flop stage with
//   its own valid bit.
// Reset (aresetn low, synchronous): all valid bits clear, colour count
//   returns to two, palette to black then white.
// Stall: when m_tready is low the result is held and a skid register takes
//   one more if one arrives; s_tready then drops and the whole pipeline holds in place.
// ----------------------------------------------------------------------------
module gradient_color_map import gcm_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_wdata,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // [17:0] position, [23:18] zero
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata    // [7:0] red, [15:8] green, [23:16] blue
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] count_reg;
    logic [REG_W-1:0] col01_reg;
    logic [REG_W-1:0] col23_reg;
    logic [REG_W-1:0] col45_reg;
    logic [REG_W-1:0] col67_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CNT_W'(2);
            col01_reg <= 48'hFFFF_FF00_0000;
            col23_reg <= '0;
            col45_reg <= '0;
            col67_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_COLOR_COUNT: count_reg <= cfg_wdata[CNT_W-1:0];
                REG_COLORS_0_1:  col01_reg <= cfg_wdata;
                REG_COLORS_2_3:  col23_reg <= cfg_wdata;
                REG_COLORS_4_5:  col45_reg <= cfg_wdata;
                REG_COLORS_6_7:  col67_reg <= cfg_wdata;
                default: ;      // drop writes beyond the register list
            endcase
        end
    end

    // Colour count clamped to the palette size; zero means black output
    logic [CNT_W-1:0]     n_eff;
    logic [SEL_W-1:0]     nm1;
    logic                 black;
    logic [4*REG_W-1:0]   palette;

    assign n_eff   = (count_reg > CNT_W'(MAX_COLORS)) ? CNT_W'(MAX_COLORS) : count_reg;
    assign nm1     = (n_eff == '0) ? '0 : SEL_W'(n_eff - 1'b1);
    assign black   = (n_eff == '0);
    assign palette = {col67_reg, col45_reg, col23_reg, col01_reg};

    // ------------------------------------------------------------------
    // Pipeline control: every stage advances while the skid stage is free
    // ------------------------------------------------------------------
    logic   en;
    logic   v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    pixel_t pix7;
    pixel_t m_pix;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    assign s_tready = en;

    // ------------------------------------------------------------------
    // Stage 1: clamp position, quantise to a table point
    // ------------------------------------------------------------------
    logic [POS_W-1:0]     pos;
    logic [T_W-1:0]       t;
    logic [T_W+IDX_W-1:0] tprod;
    logic [IDX_W-1:0]     idx1_next;
    logic [IDX_W-1:0]     idx1_reg;

    assign pos = s_tdata[POS_W-1:0];

    always_comb begin
        if (pos[POS_W-1]) begin
            t = '0;
        end else if (pos[T_W-1:0] > ONE_Q16) begin
            t = ONE_Q16;
        end else begin
            t = pos[T_W-1:0];
        end
    end

    // t * span / 65536: the divide is a shift
    assign tprod     = {{IDX_W{1'b0}}, t} * {{T_W{1'b0}}, SPAN};
    assign idx1_next = tprod[16 +: IDX_W];

    // ------------------------------------------------------------------
    // Stage 2: place the table point among the control colours
    // ------------------------------------------------------------------
    logic [P_W-1:0] p2_next;
    logic [P_W-1:0] p2_reg;

    assign p2_next = {{SEL_W{1'b0}}, idx1_reg} * {{IDX_W{1'b0}}, nm1};

    // ------------------------------------------------------------------
    // Stage 3: lower colour index = p / span, by independent compares
    // ------------------------------------------------------------------
    logic [SEL_W-1:0] lower3_next;
    logic [SEL_W-1:0] lower3_reg;
    logic [P_W-1:0]   p3_reg;

    always_comb begin
        lower3_next = '0;
        for (int k = 1; k < MAX_COLORS; k++) begin
            if (p2_reg >= P_W'(k * SPAN_INT)) begin
                lower3_next = SEL_W'(k);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: remainder, upper index, fetch both control colours
    // ------------------------------------------------------------------
    logic [P_W-1:0]   base4;
    rem_t             rem4_next;
    rem_t             rem4_reg;
    logic [SEL_W-1:0] upper4;
    color_t           ca4_next, cb4_next;
    color_t           ca4_reg, cb4_reg;

    assign base4     = {{IDX_W{1'b0}}, lower3_reg} * {{SEL_W{1'b0}}, SPAN};
    assign rem4_next = rem_t'(p3_reg - base4);
    // lower never exceeds n-1, so the upper index saturates there
    assign upper4    = (lower3_reg == nm1) ? lower3_reg : SEL_W'(lower3_reg + 1'b1);
    // with no colours blend black with black, which stays black
    assign ca4_next  = black ? '0 : pick_color(palette, lower3_reg);
    assign cb4_next  = black ? '0 : pick_color(palette, upper4);

    always_ff @(posedge aclk) begin
        if (en) begin
            idx1_reg   <= idx1_next;
            p2_reg     <= p2_next;
            p3_reg     <= p2_reg;
            lower3_reg <= lower3_next;
            rem4_reg   <= rem4_next;
            ca4_reg    <= ca4_next;
            cb4_reg    <= cb4_next;
        end
    end

    // ------------------------------------------------------------------
    // Stages 5 to 7: per-channel blend and rounded divide
    // ------------------------------------------------------------------
    gcm_chan u_chan_red (
        .aclk (aclk),
        .en   (en),
        .a    (ca4_reg[16 +: CHAN_W]),
        .b    (cb4_reg[16 +: CHAN_W]),
        .rem  (rem4_reg),
        .q    (pix7.red)
    );

    gcm_chan u_chan_green (
        .aclk (aclk),
        .en   (en),
        .a    (ca4_reg[8 +: CHAN_W]),
        .b    (cb4_reg[8 +: CHAN_W]),
        .rem  (rem4_reg),
        .q    (pix7.green)
    );

    gcm_chan u_chan_blue (
        .aclk (aclk),
        .en   (en),
        .a    (ca4_reg[0 +: CHAN_W]),
        .b    (cb4_reg[0 +: CHAN_W]),
        .rem  (rem4_reg),
        .q    (pix7.blue)
    );

    // ------------------------------------------------------------------
    // Output register and skid stage
    // ------------------------------------------------------------------
    gcm_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v7_reg),
        .in_ready  (en),
        .in_data   (pix7),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_pix)
    );

    assign m_tdata = m_pix;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_idx_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg |-> (idx1_reg <= SPAN))
        else $error("table index beyond the last table point");

    a_lower_in_palette: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg |-> (lower3_reg <= nm1))
        else $error("lower colour index beyond the colours in use");

    a_rem_below_span: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg |-> (rem4_reg < SPAN || SPAN == '0))
        else $error("blend remainder not below the span");

endmodule
